### hdl/mclp_pkg.sv
// Shared types, codes and character constants of the monitor command line parser.
// No dependencies; every other file imports this package.
package mclp_pkg;

  localparam int unsigned HEX_DIGITS_DEF = 8;
  localparam int unsigned ADDR_W         = 32;
  localparam int unsigned CFG_IDX_W      = 2;

  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_X_UP  = 8'h58;
  localparam logic [7:0] CH_X_LO  = 8'h78;
  localparam logic [7:0] CH_CASE  = 8'h20;

  localparam logic [7:0] CH_L_LO  = 8'h6C;
  localparam logic [7:0] CH_G_LO  = 8'h67;
  localparam logic [7:0] CH_R_LO  = 8'h72;
  localparam logic [7:0] CH_M_LO  = 8'h6D;
  localparam logic [7:0] CH_K_LO  = 8'h6B;
  localparam logic [7:0] CH_F_LO  = 8'h66;

  localparam logic [CFG_IDX_W-1:0] CFG_RAM_LOW   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_RAM_HIGH  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_END = 2'd2;

  typedef enum logic [2:0] {
    CMD_EMPTY   = 3'd0,
    CMD_LOAD    = 3'd1,
    CMD_GO      = 3'd2,
    CMD_READ    = 3'd3,
    CMD_MUSIC   = 3'd4,
    CMD_LEDS    = 3'd5,
    CMD_FIB     = 3'd6,
    CMD_UNKNOWN = 3'd7
  } cmd_e;

  typedef enum logic [1:0] {
    ERR_NONE   = 2'd0,
    ERR_PREFIX = 2'd1,
    ERR_DIGIT  = 2'd2,
    ERR_DELIM  = 2'd3
  } err_e;

  typedef enum logic [6:0] {
    PH_SKIP   = 7'b0000001,
    PH_LETTER = 7'b0000010,
    PH_SPACES = 7'b0000100,
    PH_PREFIX = 7'b0001000,
    PH_DIGITS = 7'b0010000,
    PH_DELIM  = 7'b0100000,
    PH_DONE   = 7'b1000000
  } phase_e;

  typedef struct packed {
    logic [ADDR_W-1:0] ram_low;
    logic [ADDR_W-1:0] ram_high;
    logic [ADDR_W-1:0] image_end;
  } mclp_bounds_t;

  typedef struct packed {
    cmd_e              command;
    err_e              hex_error;
    logic [ADDR_W-1:0] address;
    logic              address_ok;
  } mclp_result_t;

  typedef struct packed {
    logic       valid;
    logic [3:0] value;
  } hex_digit_t;

  function automatic hex_digit_t hex_decode(input logic [7:0] c);
    hex_digit_t r;
    r.valid = 1'b1;
    r.value = c[3:0];
    if (c inside {[8'h30:8'h39]}) begin
      r.value = c[3:0];
    end else if (c inside {[8'h41:8'h46], [8'h61:8'h66]}) begin
      r.value = c[3:0] + 4'd9;
    end else begin
      r.valid = 1'b0;
    end
    return r;
  endfunction

  function automatic cmd_e letter_command(input logic [7:0] c);
    cmd_e r;
    case (c | CH_CASE)
      CH_L_LO: r = CMD_LOAD;
      CH_G_LO: r = CMD_GO;
      CH_R_LO: r = CMD_READ;
      CH_M_LO: r = CMD_MUSIC;
      CH_K_LO: r = CMD_LEDS;
      CH_F_LO: r = CMD_FIB;
      default: r = CMD_UNKNOWN;
    endcase
    return r;
  endfunction

endpackage

### hdl/mclp_if.sv
// Valid/ready channel interfaces for characters in and parse results out.
// Depends on mclp_pkg for the address width.
interface mclp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] ch;
  logic       line_end;

  modport source (output valid, output ch, output line_end, input ready);
  modport sink (input valid, input ch, input line_end, output ready);
endinterface

interface mclp_out_if
  import mclp_pkg::*;
;
  logic              valid;
  logic              ready;
  logic [2:0]        command;
  logic [1:0]        hex_error;
  logic [ADDR_W-1:0] address;
  logic              address_ok;

  modport source (output valid, output command, output hex_error, output address,
                  output address_ok, input ready);
  modport sink (input valid, input command, input hex_error, input address,
                input address_ok, output ready);
endinterface

### hdl/mclp_parser.sv
// Per-character parse state and line result logic of the command line parser.
// Depends on mclp_pkg.
module mclp_parser
  import mclp_pkg::*;
#(
  parameter int unsigned HEX_DIGITS = HEX_DIGITS_DEF
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         item_take_i,
  input  logic [7:0]   ch_i,
  input  logic         line_end_i,
  input  mclp_bounds_t bounds_i,
  output logic         result_valid_o,
  output mclp_result_t result_o
);

  localparam int unsigned CNT_W = $clog2(HEX_DIGITS + 1);
  localparam logic [CNT_W-1:0] LAST_DIGIT = CNT_W'(HEX_DIGITS - 1);

  phase_e             phase_q, phase_d;
  cmd_e               cmd_q, cmd_d;
  err_e               err_q, err_d;
  logic [CNT_W-1:0]   count_q, count_d;
  logic [ADDR_W-1:0]  acc_q, acc_d;
  hex_digit_t         digit;
  mclp_result_t       res;

  assign digit = hex_decode(ch_i);

  always_comb begin
    phase_d = phase_q;
    cmd_d   = cmd_q;
    err_d   = err_q;
    count_d = count_q;
    acc_d   = acc_q;
    if (item_take_i && line_end_i) begin
      phase_d = PH_SKIP;
      cmd_d   = CMD_EMPTY;
      err_d   = ERR_NONE;
      count_d = '0;
      acc_d   = '0;
    end else if (item_take_i) begin
      case (phase_q)
        PH_SKIP: begin
          if (ch_i != CH_SPACE && ch_i != CH_NUL) begin
            cmd_d   = letter_command(ch_i);
            phase_d = (cmd_d inside {CMD_LOAD, CMD_GO, CMD_READ}) ? PH_LETTER : PH_DONE;
          end
        end
        PH_LETTER: begin
          if (ch_i == CH_SPACE) begin
            phase_d = PH_SPACES;
          end else begin
            cmd_d   = CMD_UNKNOWN;
            phase_d = PH_DONE;
          end
        end
        PH_SPACES: begin
          if (ch_i == CH_ZERO) begin
            phase_d = PH_PREFIX;
          end else if (ch_i != CH_SPACE) begin
            err_d   = ERR_PREFIX;
            phase_d = PH_DONE;
          end
        end
        PH_PREFIX: begin
          if (ch_i == CH_X_LO || ch_i == CH_X_UP) begin
            phase_d = PH_DIGITS;
            count_d = '0;
            acc_d   = '0;
          end else begin
            err_d   = ERR_PREFIX;
            phase_d = PH_DONE;
          end
        end
        PH_DIGITS: begin
          if (digit.valid) begin
            acc_d   = {acc_q[ADDR_W-5:0], digit.value};
            count_d = count_q + CNT_W'(1);
            if (count_q == LAST_DIGIT) begin
              phase_d = PH_DELIM;
            end
          end else begin
            err_d   = ERR_DIGIT;
            phase_d = PH_DONE;
          end
        end
        PH_DELIM: begin
          if (!(ch_i == CH_NUL || ch_i == CH_SPACE || ch_i == CH_CR || ch_i == CH_LF)) begin
            err_d = ERR_DELIM;
          end
          phase_d = PH_DONE;
        end
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    res.command    = cmd_q;
    res.hex_error  = ERR_NONE;
    res.address    = '0;
    res.address_ok = 1'b0;
    if (cmd_q inside {CMD_LOAD, CMD_GO, CMD_READ}) begin
      case (phase_q)
        PH_LETTER:            res.command   = CMD_UNKNOWN;
        PH_SPACES, PH_PREFIX: res.hex_error = ERR_PREFIX;
        PH_DIGITS:            res.hex_error = ERR_DIGIT;
        default:              res.hex_error = err_q;
      endcase
      if (res.command == CMD_UNKNOWN) begin
        res.hex_error = ERR_NONE;
      end else if (res.hex_error == ERR_NONE) begin
        res.address    = acc_q;
        res.address_ok = (acc_q < bounds_i.ram_high) && (acc_q >= bounds_i.ram_low) &&
                         (acc_q > bounds_i.image_end) && (acc_q[1:0] == 2'b00);
      end
    end
  end

  assign result_valid_o = item_take_i && line_end_i;
  assign result_o       = res;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_SKIP;
      cmd_q   <= CMD_EMPTY;
      err_q   <= ERR_NONE;
      count_q <= '0;
      acc_q   <= '0;
    end else begin
      phase_q <= phase_d;
      cmd_q   <= cmd_d;
      err_q   <= err_d;
      count_q <= count_d;
      acc_q   <= acc_d;
    end
  end

endmodule

### hdl/monitor_command_line_parser_top.sv
// Top level of the monitor command line parser: bound registers, parser, result queue.
// Depends on mclp_pkg, mclp_if and mclp_parser.
//
//   channel   dir   handshake      payload
//   item_i    in    valid/ready    ch[7:0], line_end
//   result_o  out   valid/ready    command[2:0], hex_error[1:0], address[31:0], address_ok
//   cfg       in    cfg_we_i       cfg_index_i[1:0], cfg_wdata_i[31:0]
//
// One character per cycle while item_i is ready; the parse state updates in the accepting cycle.
// A line end delivers its result from an output register, via the skid entry if the output stalls.
// A two-entry result queue keeps item_i ready while one result waits;
// item_i stalls only when both entries are full.
// Reset clears the parse state, the queue and all three bound registers.
module monitor_command_line_parser_top
  import mclp_pkg::*;
#(
  parameter int unsigned HEX_DIGITS = HEX_DIGITS_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [ADDR_W-1:0]    cfg_wdata_i,
  mclp_in_if.sink              item_i,
  mclp_out_if.source           result_o
);

  mclp_bounds_t bounds_q;
  logic         take;
  logic         new_valid;
  mclp_result_t new_res;
  logic         out_valid_q, skid_valid_q;
  mclp_result_t out_q, skid_q;
  logic         out_free;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bounds_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        CFG_RAM_LOW:   bounds_q.ram_low   <= cfg_wdata_i;
        CFG_RAM_HIGH:  bounds_q.ram_high  <= cfg_wdata_i;
        CFG_IMAGE_END: bounds_q.image_end <= cfg_wdata_i;
        default: begin
        end
      endcase
    end
  end

  assign item_i.ready = !skid_valid_q;
  assign take         = item_i.valid && item_i.ready;

  mclp_parser #(
    .HEX_DIGITS(HEX_DIGITS)
  ) u_parser (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .item_take_i   (take),
    .ch_i          (item_i.ch),
    .line_end_i    (item_i.line_end),
    .bounds_i      (bounds_q),
    .result_valid_o(new_valid),
    .result_o      (new_res)
  );

  assign out_free = !out_valid_q || result_o.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (out_free) begin
      if (skid_valid_q) begin
        skid_valid_q <= 1'b0;
      end else begin
        out_valid_q <= new_valid;
      end
    end else if (new_valid) begin
      skid_valid_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_free) begin
      if (skid_valid_q) begin
        out_q <= skid_q;
      end else if (new_valid) begin
        out_q <= new_res;
      end
    end else if (new_valid) begin
      skid_q <= new_res;
    end
  end

  assign result_o.valid      = out_valid_q;
  assign result_o.command    = out_q.command;
  assign result_o.hex_error  = out_q.hex_error;
  assign result_o.address    = out_q.address;
  assign result_o.address_ok = out_q.address_ok;

endmodule

### hdl/mclp_checker.sv
// Port-level checks of the command line parser, bound to the top level.
// Depends on mclp_pkg and monitor_command_line_parser_top.
module mclp_checker
  import mclp_pkg::*;
(
  input logic              clk_i,
  input logic              rst_ni,
  input logic              in_valid_i,
  input logic              in_ready_i,
  input logic              in_line_end_i,
  input logic              out_valid_i,
  input logic              out_ready_i,
  input logic [2:0]        command_i,
  input logic [1:0]        hex_error_i,
  input logic [ADDR_W-1:0] address_i,
  input logic              address_ok_i
);

  logic addr_cmd;
  assign addr_cmd = (command_i == CMD_LOAD) || (command_i == CMD_GO) ||
                    (command_i == CMD_READ);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i)
    else $error("result dropped while stalled");

  a_result_from_line_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_i) |-> $past(in_valid_i && in_ready_i && in_line_end_i))
    else $error("result without a line end");

  a_plain_cmd_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !addr_cmd |-> hex_error_i == ERR_NONE && address_i == '0 && !address_ok_i)
    else $error("address fields set for a command without address");

  a_ok_needs_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && address_ok_i |-> hex_error_i == ERR_NONE && address_i[1:0] == 2'b00)
    else $error("address accepted with error or misalignment");

endmodule

bind monitor_command_line_parser_top mclp_checker u_mclp_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_valid_i   (item_i.valid),
  .in_ready_i   (item_i.ready),
  .in_line_end_i(item_i.line_end),
  .out_valid_i  (result_o.valid),
  .out_ready_i  (result_o.ready),
  .command_i    (result_o.command),
  .hex_error_i  (result_o.hex_error),
  .address_i    (result_o.address),
  .address_ok_i (result_o.address_ok)
);
